@@ rtl/bsfr_pkg.sv @@
`default_nettype none

package bsfr_pkg;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 5;   // width of the length registers, holds up to 31
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_USR_W = 2;

    // Positions inside the result tuser
    localparam int USR_BYTE_VALID  = 0;
    localparam int USR_STRING_DONE = 1;

    typedef logic [BYTE_W-1:0] t_byte;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLEN   = 3'd0,
        CFG_RLEN   = 3'd1,
        CFG_PAT_LO = 3'd2,
        CFG_PAT_HI = 3'd3,
        CFG_REP_LO = 3'd4,
        CFG_REP_HI = 3'd5
    } t_cfg_idx;

    // Run request handed from the window stage to the emitter
    typedef struct packed {
        logic             load;    // a new run is present
        logic [CNT_W-1:0] len;     // number of results in the run
        logic             marker;  // run is a single empty end marker
        logic             eos;     // run closes the string
    } t_run_ctl;

endpackage

`default_nettype wire

@@ rtl/bsfr_window.sv @@
`default_nettype none

module bsfr_window
    import bsfr_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int RUN_MAX     = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_byte            i_byte,
    input  wire logic             i_eos,
    input  wire logic             i_run_free,
    input  wire logic [CNT_W-1:0] i_plen,
    input  wire logic [CNT_W-1:0] i_rlen,
    input  wire t_byte            i_pattern [PATTERN_MAX],
    input  wire t_byte            i_replace [RUN_MAX],
    output logic                  o_take,
    output t_run_ctl              o_run_ctl,
    output t_byte                 o_run_bytes [RUN_MAX]
);

    localparam int CW = $clog2(PATTERN_MAX + 1);

    t_byte          r_win [PATTERN_MAX];
    logic [CW-1:0]  r_cnt;

    t_byte          n_win [PATTERN_MAX];
    logic [CW-1:0]  n_cnt;

    t_byte            w_app [RUN_MAX];
    logic [CW-1:0]    w_cnt_app;
    logic [CNT_W-1:0] w_cnt_x;
    logic             w_hit;
    logic             w_step_out;
    logic [CNT_W-1:0] w_len;
    logic             w_marker;

    assign o_take = i_valid && i_run_free;

    // Append the incoming byte and test the full window against the pattern
    always_comb begin
        w_app = '{default: '0};
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_app[i] = (CW'(i) == r_cnt) ? i_byte : r_win[i];
        end
        w_cnt_app = (r_cnt < CW'(PATTERN_MAX)) ? r_cnt + CW'(1) : r_cnt;
        w_cnt_x   = CNT_W'(w_cnt_app);

        w_hit = (w_cnt_x == i_plen);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (CNT_W'(i) < i_plen && w_app[i] != i_pattern[i]) begin
                w_hit = 1'b0;
            end
        end
        w_step_out = !w_hit && (w_cnt_x >= i_plen);

        // Size the run: replacement, whole window on end of string, oldest byte, or an empty end marker
        if (w_hit) begin
            w_len = i_rlen;
        end else if (i_eos) begin
            w_len = w_cnt_x;
        end else if (w_step_out) begin
            w_len = CNT_W'(1);
        end else begin
            w_len = '0;
        end
        w_marker = i_eos && (w_len == '0);
        if (w_marker) begin
            w_len = CNT_W'(1);
        end
    end

    // Select the run bytes
    always_comb begin
        for (int i = 0; i < RUN_MAX; i++) begin
            o_run_bytes[i] = w_hit ? i_replace[i] : w_app[i];
        end
        o_run_ctl.load   = o_take && (w_len != '0);
        o_run_ctl.len    = w_len;
        o_run_ctl.marker = w_marker;
        o_run_ctl.eos    = i_eos;
    end

    // Next window: clear on hit or end of string, drop oldest on step out
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            n_win[i] = w_app[i];
        end
        n_cnt = w_cnt_app;
        if (w_hit || i_eos) begin
            n_cnt = '0;
        end else if (w_step_out) begin
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                n_win[i] = w_app[i + 1];
            end
            n_cnt = w_cnt_app - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_take) begin
            r_cnt <= n_cnt;
            r_win <= n_win;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bsfr_emit.sv @@
`default_nettype none

module bsfr_emit
    import bsfr_pkg::*;
#(
    parameter int RUN_MAX = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_run_ctl i_run_ctl,
    input  wire t_byte    i_run_bytes [RUN_MAX],
    output logic          o_run_free,
    input  wire logic     i_tready,
    output logic          o_tvalid,
    output t_byte         o_tdata,
    output logic          o_tlast,
    output logic [OUT_USR_W-1:0] o_tuser
);

    t_byte            r_buf [RUN_MAX];
    logic [CNT_W-1:0] r_len;
    logic             r_marker;
    logic             r_eos;

    logic             r_out_valid;
    t_byte            r_out_byte;
    logic             r_out_bvalid;
    logic             r_out_last;
    logic             r_out_done;

    logic             w_pop;

    // Move the head of the run into the output register when it is free
    assign w_pop      = (r_len != '0) && (!r_out_valid || i_tready);
    assign o_run_free = (r_len == '0) || (r_len == CNT_W'(1) && w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Output register
            if (w_pop) begin
                r_out_valid  <= 1'b1;
                r_out_byte   <= r_marker ? '0 : r_buf[0];
                r_out_bvalid <= !r_marker;
                r_out_last   <= (r_len == CNT_W'(1));
                r_out_done   <= (r_len == CNT_W'(1)) && r_eos;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end

            // Run buffer: load a new run or advance by one
            if (i_run_ctl.load) begin
                r_buf    <= i_run_bytes;
                r_len    <= i_run_ctl.len;
                r_marker <= i_run_ctl.marker;
                r_eos    <= i_run_ctl.eos;
            end else if (w_pop) begin
                for (int i = 0; i < RUN_MAX - 1; i++) begin
                    r_buf[i] <= r_buf[i + 1];
                end
                r_len <= r_len - CNT_W'(1);
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_last;
    always_comb begin
        o_tuser                  = '0;
        o_tuser[USR_BYTE_VALID]  = r_out_bvalid;
        o_tuser[USR_STRING_DONE] = r_out_done;
    end

endmodule

`default_nettype wire

@@ rtl/byte_stream_find_replace_top.sv @@
// Path: an accepted byte passes the input register, the run buffer and the output register.
// Throughput: one byte per cycle while each byte yields at most one result and the output is
//   ready; a byte that yields a run of several results (replacement or end-of-string flush)
//   holds the input while the run buffer drains it, one result per cycle while the output accepts.
// Reset: synchronous, active low; clears the window, run buffer, valid flags and
//   restores every configuration register to its default.
`default_nettype none

module byte_stream_find_replace_top
    import bsfr_pkg::*;
#(
    parameter int PATTERN_MAX     = 16,
    parameter int REPLACEMENT_MAX = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    input  wire logic                 s_axis_tlast,   // end_of_string
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [7:0] out_byte
    output logic                      m_axis_tlast,   // run_last
    output logic [OUT_USR_W-1:0]      m_axis_tuser    // [0] byte_valid, [1] string_done
);

    localparam int RUN_MAX = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX :
                             ((REPLACEMENT_MAX > 0) ? REPLACEMENT_MAX : 1);

    // Configuration registers
    logic [CNT_W-1:0]   r_plen_cfg;
    logic [CNT_W-1:0]   r_rlen_cfg;
    logic [2*CFG_W-1:0] r_pat;
    logic [2*CFG_W-1:0] r_rep;

    // Input register
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_eos;

    logic             w_take;
    logic             w_run_free;
    logic [CNT_W-1:0] w_plen;
    logic [CNT_W-1:0] w_rlen;
    t_byte            w_pattern [PATTERN_MAX];
    t_byte            w_replace [RUN_MAX];
    t_run_ctl         w_run_ctl;
    t_byte            w_run_bytes [RUN_MAX];

    // Decode configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen_cfg <= CNT_W'(1);
            r_rlen_cfg <= '0;
            r_pat      <= '0;
            r_rep      <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_PLEN:   r_plen_cfg           <= i_cfg_wdata[CNT_W-1:0];
                CFG_RLEN:   r_rlen_cfg           <= i_cfg_wdata[CNT_W-1:0];
                CFG_PAT_LO: r_pat[CFG_W-1:0]     <= i_cfg_wdata;
                CFG_PAT_HI: r_pat[2*CFG_W-1:CFG_W] <= i_cfg_wdata;
                CFG_REP_LO: r_rep[CFG_W-1:0]     <= i_cfg_wdata;
                CFG_REP_HI: r_rep[2*CFG_W-1:CFG_W] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp lengths to the supported range
    always_comb begin
        if (r_plen_cfg == '0) begin
            w_plen = CNT_W'(1);
        end else if (r_plen_cfg > CNT_W'(PATTERN_MAX)) begin
            w_plen = CNT_W'(PATTERN_MAX);
        end else begin
            w_plen = r_plen_cfg;
        end
        w_rlen = (r_rlen_cfg > CNT_W'(REPLACEMENT_MAX)) ? CNT_W'(REPLACEMENT_MAX) : r_rlen_cfg;
    end

    // Unpack pattern and replacement bytes
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_pattern[i] = r_pat[i*BYTE_W +: BYTE_W];
        end
        for (int i = 0; i < RUN_MAX; i++) begin
            w_replace[i] = r_rep[i*BYTE_W +: BYTE_W];
        end
    end

    // Hold the request until the window stage takes it
    assign s_axis_tready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
            r_in_byte  <= s_axis_tdata;
            r_in_eos   <= s_axis_tlast;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    bsfr_window #(
        .PATTERN_MAX (PATTERN_MAX),
        .RUN_MAX     (RUN_MAX)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .i_eos       (r_in_eos),
        .i_run_free  (w_run_free),
        .i_plen      (w_plen),
        .i_rlen      (w_rlen),
        .i_pattern   (w_pattern),
        .i_replace   (w_replace),
        .o_take      (w_take),
        .o_run_ctl   (w_run_ctl),
        .o_run_bytes (w_run_bytes)
    );

    bsfr_emit #(
        .RUN_MAX (RUN_MAX)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_ctl   (w_run_ctl),
        .i_run_bytes (w_run_bytes),
        .o_run_free  (w_run_free),
        .i_tready    (m_axis_tready),
        .o_tvalid    (m_axis_tvalid),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast),
        .o_tuser     (m_axis_tuser)
    );

    // End of string always closes the run of its item
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USR_STRING_DONE] |-> m_axis_tlast)
        else $error("string_done without run_last");

    // An empty marker carries a zero byte and ends the string
    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[USR_BYTE_VALID] |->
            m_axis_tdata == '0 && m_axis_tuser[USR_STRING_DONE] && m_axis_tlast)
        else $error("malformed end marker");

    // A pending input byte is kept until the window stage takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_take |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_eos))
        else $error("input register lost a pending byte");

endmodule

`default_nettype wire

@@ verif/byte_stream_find_replace_checker.sv @@
`timescale 1ns / 100ps

module byte_stream_find_replace_checker
    import bsfr_pkg::*;
#(
    parameter int PATTERN_MAX     = 16,
    parameter int REPLACEMENT_MAX = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    input  logic                 s_axis_tlast,   // end_of_string
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [7:0]           m_axis_tdata,   // [7:0] out_byte
    input  logic                 m_axis_tlast,   // run_last
    input  logic [OUT_USR_W-1:0] m_axis_tuser,   // [0] byte_valid, [1] string_done
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_result_count,
    output int                   o_hit_count
);

    typedef struct packed {
        t_byte out_byte;
        logic  byte_valid;
        logic  run_last;
        logic  string_done;
    } t_result;

    // Shadow copy of the configuration registers
    logic [CNT_W-1:0] pat_len_r;
    logic [CNT_W-1:0] rep_len_r;
    logic [CFG_W-1:0] pat_lo_r;
    logic [CFG_W-1:0] pat_hi_r;
    logic [CFG_W-1:0] rep_lo_r;
    logic [CFG_W-1:0] rep_hi_r;

    // Shadow copy of the match window
    t_byte   win [PATTERN_MAX];
    int      win_fill;

    t_result expected_q [$];
    int      fail_cnt   = 0;
    int      result_cnt = 0;
    int      hit_cnt    = 0;

    assign o_fail_count   = fail_cnt;
    assign o_result_count = result_cnt;
    assign o_hit_count    = hit_cnt;

    // Pick byte i out of a low/high register pair
    function automatic t_byte lane(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                   input int i);
        if (i < 8) begin
            return lo[8*i +: 8];
        end
        return hi[8*(i-8) +: 8];
    endfunction

    // Advance the window by one accepted byte and queue the results it causes
    task automatic predict_byte(input t_byte b, input logic eos);
        t_result run [$];
        t_result r;
        int      plen;
        int      rlen;
        bit      hit;
        plen = pat_len_r;
        rlen = rep_len_r;
        if (plen < 1) plen = 1;
        if (plen > PATTERN_MAX) plen = PATTERN_MAX;
        if (rlen > REPLACEMENT_MAX) rlen = REPLACEMENT_MAX;

        if (win_fill < PATTERN_MAX) begin
            win[win_fill] = b;
            win_fill++;
        end

        // Test for a match only when the window holds exactly the pattern length
        if (win_fill == plen) begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++) begin
                if (win[i] != lane(pat_lo_r, pat_hi_r, i)) hit = 1'b0;
            end
            if (hit) begin
                for (int i = 0; i < rlen; i++) begin
                    r = '0;
                    r.out_byte   = lane(rep_lo_r, rep_hi_r, i);
                    r.byte_valid = 1'b1;
                    run.push_back(r);
                end
                win_fill = 0;
                hit_cnt++;
            end
        end

        // Emit the oldest byte of a full (or overfull) window
        if (win_fill >= plen && win_fill > 0) begin
            r = '0;
            r.out_byte   = win[0];
            r.byte_valid = 1'b1;
            run.push_back(r);
            for (int i = 0; i < win_fill - 1; i++) win[i] = win[i+1];
            win_fill--;
        end

        // Flush at end of string, with an empty marker if nothing came out
        if (eos) begin
            for (int i = 0; i < win_fill; i++) begin
                r = '0;
                r.out_byte   = win[i];
                r.byte_valid = 1'b1;
                run.push_back(r);
            end
            win_fill = 0;
            if (run.size() == 0) begin
                run.push_back('0);
            end
            run[run.size()-1].string_done = 1'b1;
        end

        if (run.size() > 0) begin
            run[run.size()-1].run_last = 1'b1;
        end
        foreach (run[k]) expected_q.push_back(run[k]);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            pat_len_r = CNT_W'(1);
            rep_len_r = '0;
            pat_lo_r  = '0;
            pat_hi_r  = '0;
            rep_lo_r  = '0;
            rep_hi_r  = '0;
            foreach (win[i]) win[i] = '0;
            win_fill  = 0;
            expected_q.delete();
        end else begin
            // Compare each delivered result against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_byte    = m_axis_tdata;
                got.byte_valid  = m_axis_tuser[USR_BYTE_VALID];
                got.run_last    = m_axis_tlast;
                got.string_done = m_axis_tuser[USR_STRING_DONE];
                result_cnt++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                    fail_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("byte_valid", want.byte_valid, got.byte_valid);
                    check_field("run_last", want.run_last, got.run_last);
                    check_field("string_done", want.string_done, got.string_done);
                end
            end

            // Track register writes; unknown indexes are dropped
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_PLEN:   pat_len_r = i_cfg_wdata[CNT_W-1:0];
                    CFG_RLEN:   rep_len_r = i_cfg_wdata[CNT_W-1:0];
                    CFG_PAT_LO: pat_lo_r  = i_cfg_wdata;
                    CFG_PAT_HI: pat_hi_r  = i_cfg_wdata;
                    CFG_REP_LO: rep_lo_r  = i_cfg_wdata;
                    CFG_REP_HI: rep_hi_r  = i_cfg_wdata;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                predict_byte(s_axis_tdata, s_axis_tlast);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

@@ verif/byte_stream_find_replace_top_tb.sv @@
`timescale 1ns / 100ps

module byte_stream_find_replace_top_tb;
    import bsfr_pkg::*;

    localparam int RAND_ITEMS  = 280;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 6;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} t_idle_mode;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;
    logic [OUT_USR_W-1:0] m_axis_tuser;

    int fail_count;
    int pending;
    int result_count;
    int hit_count;

    t_idle_mode tx_mode     = IDLE_SPARSE;
    t_idle_mode rx_mode     = IDLE_SPARSE;
    int         rx_hold_req = 0;
    int         bytes_sent   = 0;
    int         strings_sent = 0;
    int         setups_done  = 0;

    byte_stream_find_replace_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    byte_stream_find_replace_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_hit_count    (hit_count)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort a hung run
    initial begin
        #6000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int draw_wait(input t_idle_mode m);
        case (m)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            default:     return $urandom_range(0, 16);
        endcase
    endfunction

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input t_byte b, input logic eos);
        int gap;
        gap = draw_wait(tx_mode);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        if (eos) strings_sent++;
    endtask

    // Drop the request, wait out every expected result, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write one register; the enable stays high until cfg_close
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic cfg_close();
        i_cfg_wr_en <= 1'b0;
        setups_done++;
    endtask

    task automatic write_setup(input int plen, input int rlen,
                               input logic [127:0] pat, input logic [127:0] rep);
        cfg_put(CFG_PLEN, CFG_W'(plen));
        cfg_put(CFG_RLEN, CFG_W'(rlen));
        cfg_put(CFG_PAT_LO, pat[63:0]);
        cfg_put(CFG_PAT_HI, pat[127:64]);
        cfg_put(CFG_REP_LO, rep[63:0]);
        cfg_put(CFG_REP_HI, rep[127:64]);
        cfg_close();
    endtask

    // Result sink: random stall per result, plus one long hold-off on request
    initial begin
        int stall;
        forever begin
            stall = draw_wait(rx_mode);
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Stimulus
    initial begin
        logic [127:0] pat_bits;
        logic [127:0] rep_bits;
        t_byte        text [$];
        t_byte        a0;
        t_byte        a1;
        t_byte        b;
        int           plen;
        int           rlen;
        int           eff;
        int           rand_items;
        int           phase;
        int           quota;
        int           phase_items;
        int           len;
        int           pick;
        int           cut;
        int           sym;
        bit           full_pat;
        bit           close_str;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults: one-byte pattern 0x00, empty replacement
        tx_mode = IDLE_FULL;
        rx_mode = IDLE_FULL;
        send_byte(8'h00, 1'b1);     // whole string removed: empty end marker
        send_byte(8'hFF, 1'b1);

        // Three-byte pattern, match lands on the final byte
        wait_idle();
        pat_bits        = {$urandom, $urandom, $urandom, $urandom};
        pat_bits[23:0]  = 24'h636261;
        rep_bits        = {$urandom, $urandom, $urandom, $urandom};
        write_setup(3, 2, pat_bits, rep_bits);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);

        // Longest pattern and longest replacement
        wait_idle();
        pat_bits = {$urandom, $urandom, $urandom, $urandom};
        rep_bits = {$urandom, $urandom, $urandom, $urandom};
        write_setup(16, 16, pat_bits, rep_bits);
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_NONE;
        for (int i = 0; i < 16; i++) send_byte(pat_bits[8*i +: 8], i == 15);

        // Leave three bytes in the window, then shrink the pattern below that
        for (int i = 0; i < 3; i++) send_byte(t_byte'($urandom_range(0, 255)), 1'b0);
        wait_idle();
        cfg_put(CFG_PLEN, '0);
        cfg_put(CFG_RLEN, CFG_W'(31));
        cfg_put(CFG_SPARE_LO, '1);
        cfg_put(CFG_SPARE_HI, {$urandom, $urandom});
        cfg_close();
        send_byte(t_byte'($urandom_range(0, 255)), 1'b1);

        // Random phases: new setup, then strings built around the pattern
        rand_items = 0;
        phase      = 0;
        while (rand_items < RAND_ITEMS) begin
            a0       = t_byte'($urandom_range(0, 255));
            a1       = t_byte'($urandom_range(0, 255));
            full_pat = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < 16; i++) begin
                if (full_pat) pat_bits[8*i +: 8] = t_byte'($urandom_range(0, 255));
                else          pat_bits[8*i +: 8] = $urandom_range(0, 1) ? a1 : a0;
            end
            rep_bits = {$urandom, $urandom, $urandom, $urandom};
            pick = $urandom_range(0, 7);
            if (pick == 0)      plen = $urandom_range(0, 31);
            else if (pick == 1) plen = $urandom_range(5, 16);
            else                plen = $urandom_range(1, 4);
            rlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16);
            case (phase)
                0: begin
                    // a byte equal to the pattern is a hit that expands to 16 results
                    plen = 1;
                    rlen = 16;
                    pat_bits[7:0] = a0;
                end
                1: begin
                    plen = 31;
                    rlen = 31;
                end
                2: begin
                    plen = 16;
                    rlen = 0;
                end
                default: ;
            endcase

            wait_idle();
            write_setup(plen, rlen, pat_bits, rep_bits);
            tx_mode = t_idle_mode'($urandom_range(0, 2));
            rx_mode = t_idle_mode'($urandom_range(0, 2));
            if (phase == 0) begin
                tx_mode     = IDLE_NONE;
                rx_hold_req = HOLD_CYCLES;
            end
            eff = (plen < 1) ? 1 : ((plen > 16) ? 16 : plen);

            quota       = $urandom_range(20, 40);
            phase_items = 0;
            while (phase_items < quota) begin
                text.delete();
                len = $urandom_range(1, 12);
                while (text.size() < len) begin
                    pick = $urandom_range(0, 5);
                    if (pick < 2) begin
                        for (int i = 0; i < eff; i++) text.push_back(pat_bits[8*i +: 8]);
                    end else if (pick == 2) begin
                        // broken copy of the pattern
                        cut = $urandom_range(0, eff - 1);
                        for (int i = 0; i < cut; i++) text.push_back(pat_bits[8*i +: 8]);
                    end else begin
                        sym = $urandom_range(0, 9);
                        if (sym < 4)      b = a0;
                        else if (sym < 8) b = a1;
                        else              b = t_byte'($urandom_range(0, 255));
                        text.push_back(b);
                    end
                end
                // now and then run on into the next string
                close_str = ($urandom_range(0, 4) != 0);
                foreach (text[k]) send_byte(text[k], close_str && (k == text.size() - 1));
                phase_items += text.size();
            end
            rand_items += phase_items;
            phase++;
        end

        wait_idle();
        $display("Run covered %0d bytes, %0d closed strings, %0d register setups,",
                 bytes_sent, strings_sent, setups_done);
        $display("%0d results compared, %0d pattern hits.", result_count, hit_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
